[rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared commands, phase actions and sequence tables of the I2C bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   localparam int unsigned PhaseTicksW = 16;
   localparam int unsigned PhaseIdxW   = 5;

   // commands
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_SACK  = 3'd4;
   localparam logic [2:0] CMD_RACK  = 3'd5;

   // word kinds on the request channel
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // what a phase does when it is entered
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_SDA_HI = 3'd1;
   localparam logic [2:0] ACT_SDA_LO = 3'd2;
   localparam logic [2:0] ACT_SCL_HI = 3'd3;
   localparam logic [2:0] ACT_SCL_LO = 3'd4;
   localparam logic [2:0] ACT_SDA_TX = 3'd5;
   localparam logic [2:0] ACT_SHIFT  = 3'd6;
   localparam logic [2:0] ACT_ACK    = 3'd7;

   typedef struct packed {
      logic [2:0] act;
      logic [2:0] bit_sel;
   } phase_act_type;

   function automatic logic [PhaseIdxW-1:0] seq_length(input logic [2:0] cmd);
      logic [PhaseIdxW-1:0] len;
      unique case (cmd)
         CMD_START: len = 5'd4;
         CMD_STOP:  len = 5'd3;
         CMD_WRITE: len = 5'd24;
         CMD_READ:  len = 5'd25;
         CMD_SACK:  len = 5'd3;
         CMD_RACK:  len = 5'd4;
         default:   len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic phase_act_type phase_decode(input logic [2:0]           cmd,
                                                  input logic [PhaseIdxW-1:0] p);
      phase_act_type        r;
      logic [PhaseIdxW-1:0] q;
      logic [1:0]           rem;
      logic [2:0]           quo;
      r.act     = ACT_NONE;
      r.bit_sel = 3'd0;
      // read byte has one leading phase before its bit groups
      q   = (cmd == CMD_READ) ? p - 5'd1 : p;
      rem = 2'd0;
      quo = 3'd0;
      // split into bit group and step within the group, eight groups of three
      for (int k = 0; k < 8; k++) begin
         if (q == 5'(3 * k)) begin
            rem = 2'd0;
            quo = 3'(k);
         end else if (q == 5'(3 * k + 1)) begin
            rem = 2'd1;
            quo = 3'(k);
         end else if (q == 5'(3 * k + 2)) begin
            rem = 2'd2;
            quo = 3'(k);
         end
      end
      unique case (cmd)
         CMD_START: begin
            priority if (p == 5'd0) r.act = ACT_SDA_HI;
            else if (p == 5'd1)     r.act = ACT_SCL_HI;
            else if (p == 5'd2)     r.act = ACT_SDA_LO;
            else                    r.act = ACT_SCL_LO;
         end
         CMD_STOP: begin
            priority if (p == 5'd0) r.act = ACT_SDA_LO;
            else if (p == 5'd1)     r.act = ACT_SCL_HI;
            else                    r.act = ACT_SDA_HI;
         end
         CMD_WRITE: begin
            priority if (rem == 2'd0) begin
               r.act     = ACT_SDA_TX;
               r.bit_sel = 3'd7 - quo;
            end else if (rem == 2'd1) begin
               r.act = ACT_SCL_HI;
            end else begin
               r.act = ACT_SCL_LO;
            end
         end
         CMD_READ: begin
            priority if (p == 5'd0) r.act = ACT_SDA_HI;
            else if (rem == 2'd0)   r.act = ACT_SCL_HI;
            else if (rem == 2'd1)   r.act = ACT_SHIFT;
            else                    r.act = ACT_SCL_LO;
         end
         CMD_SACK: begin
            priority if (p == 5'd0) r.act = ACT_SDA_TX;
            else if (p == 5'd1)     r.act = ACT_SCL_HI;
            else                    r.act = ACT_SCL_LO;
         end
         CMD_RACK: begin
            priority if (p == 5'd0) r.act = ACT_SDA_HI;
            else if (p == 5'd1)     r.act = ACT_SCL_HI;
            else if (p == 5'd2)     r.act = ACT_ACK;
            else                    r.act = ACT_SCL_LO;
         end
         default: r.act = ACT_NONE;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/i2cm_req_if.sv]
// ----------------------------------------------------------------------------
// i2cm_req_if
// Request channel of the I2C bit engine: commands and ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [2:0] command;
   logic [7:0] tx_byte;
   logic       ack_out;
   logic       sda_in;

   modport source (output valid, op, command, tx_byte, ack_out, sda_in, input ready);
   modport sink   (input valid, op, command, tx_byte, ack_out, sda_in, output ready);
endinterface

`default_nettype wire

[rtl/i2cm_rsp_if.sv]
// ----------------------------------------------------------------------------
// i2cm_rsp_if
// Response channel of the I2C bit engine: pin levels and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       rx_ack;

   modport source (output valid, scl_level, sda_drive, busy_res, done_res, rx_byte, rx_ack,
                   input ready);
   modport sink   (input valid, scl_level, sda_drive, busy_res, done_res, rx_byte, rx_ack,
                   output ready);
endinterface

`default_nettype wire

[rtl/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Bit-level I2C master: runs start, stop, byte and ack phase sequences.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  req_chan  in         op, command, tx_byte, ack_out, sda_in
//  rsp_chan  out        scl_level, sda_drive, busy_res, done_res, rx_byte, rx_ack
//  csr_*     in         phase_ticks write (16 bit)
//
//  One word per cycle sustained while responses are taken; each request word
//  yields one response word via the input register, then response register.
//  The engine state is updated as a word moves from the input register into
//  the response register. Synchronous active-high reset releases both pins.
//  A stalled response holds both stages; the input register still fills.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   i2cm_req_if.sink                              req_chan,
   i2cm_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [i2cm_pkg::PhaseTicksW-1:0] csr_wr_data
);

   localparam int unsigned TW = i2cm_pkg::PhaseTicksW;
   localparam int unsigned IW = i2cm_pkg::PhaseIdxW;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [2:0] in_cmd_ff;
   logic [7:0] in_tx_ff;
   logic       in_ack_ff;
   logic       in_sda_ff;

   // engine state
   logic [TW-1:0] phase_ticks_ff;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [7:0]    shift_ff, shift_in;
   logic          ack_seen_ff, ack_seen_in;
   logic          busy_ff, busy_in;
   logic [7:0]    tx_hold_ff, tx_hold_in;
   logic          done_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   logic [7:0] rsp_byte_ff;

   logic                    advance;
   logic                    start_cmd;
   logic                    tick_end;
   logic                    enter;
   logic [IW-1:0]           idx_inc;
   logic [TW:0]             tick_next;
   logic [7:0]              shift_base;
   i2cm_pkg::phase_act_type act;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = (req_chan.valid && req_chan.ready) ? 1'b1
                         : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in   = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   assign tick_next = {1'b0, tick_ff} + {{TW{1'b0}}, 1'b1};
   assign idx_inc   = idx_ff + {{(IW-1){1'b0}}, 1'b1};
   assign start_cmd = (in_op_ff == i2cm_pkg::OP_COMMAND) && !busy_ff
                   && (in_cmd_ff <= i2cm_pkg::CMD_RACK);
   // zero phase_ticks behaves as one
   assign tick_end  = (in_op_ff == i2cm_pkg::OP_TICK) && busy_ff
                   && (tick_next >= {1'b0, phase_ticks_ff});

   always_comb begin
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      tick_in     = tick_ff;
      busy_in     = busy_ff;
      tx_hold_in  = tx_hold_ff;
      shift_base  = shift_ff;
      done_in     = 1'b0;
      enter       = 1'b0;
      if (start_cmd) begin
         cmd_in  = in_cmd_ff;
         idx_in  = '0;
         tick_in = '0;
         busy_in = 1'b1;
         enter   = 1'b1;
         if (in_cmd_ff == i2cm_pkg::CMD_WRITE) tx_hold_in = in_tx_ff;
         else if (in_cmd_ff == i2cm_pkg::CMD_SACK) tx_hold_in = {7'd0, in_ack_ff};
         if (in_cmd_ff == i2cm_pkg::CMD_READ) shift_base = '0;
      end else if (tick_end) begin
         tick_in = '0;
         if (idx_inc >= i2cm_pkg::seq_length(cmd_ff)) begin
            busy_in = 1'b0;
            idx_in  = '0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_inc;
            enter  = 1'b1;
         end
      end else if ((in_op_ff == i2cm_pkg::OP_TICK) && busy_ff) begin
         tick_in = tick_next[TW-1:0];
      end
   end

   assign act = i2cm_pkg::phase_decode(cmd_in, idx_in);

   always_comb begin
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      shift_in    = shift_base;
      ack_seen_in = ack_seen_ff;
      if (enter) begin
         unique case (act.act)
            i2cm_pkg::ACT_SDA_HI: sda_in      = 1'b1;
            i2cm_pkg::ACT_SDA_LO: sda_in      = 1'b0;
            i2cm_pkg::ACT_SCL_HI: scl_in      = 1'b1;
            i2cm_pkg::ACT_SCL_LO: scl_in      = 1'b0;
            i2cm_pkg::ACT_SDA_TX: sda_in      = tx_hold_in[act.bit_sel];
            i2cm_pkg::ACT_SHIFT:  shift_in    = {shift_base[6:0], in_sda_ff};
            i2cm_pkg::ACT_ACK:    ack_seen_in = in_sda_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ticks_ff <= {{(TW-1){1'b0}}, 1'b1};
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         cmd_ff         <= i2cm_pkg::CMD_START;
         idx_ff         <= '0;
         tick_ff        <= '0;
         shift_ff       <= '0;
         ack_seen_ff    <= 1'b0;
         busy_ff        <= 1'b0;
         tx_hold_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) phase_ticks_ff <= csr_wr_data;
         if (advance) begin
            scl_ff      <= scl_in;
            sda_ff      <= sda_in;
            cmd_ff      <= cmd_in;
            idx_ff      <= idx_in;
            tick_ff     <= tick_in;
            shift_ff    <= shift_in;
            ack_seen_ff <= ack_seen_in;
            busy_ff     <= busy_in;
            tx_hold_ff  <= tx_hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff  <= req_chan.op;
         in_cmd_ff <= req_chan.command;
         in_tx_ff  <= req_chan.tx_byte;
         in_ack_ff <= req_chan.ack_out;
         in_sda_ff <= req_chan.sda_in;
      end
      if (advance) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= busy_in;
         rsp_done_ff <= done_in;
         rsp_byte_ff <= shift_in;
         rsp_ack_ff  <= ack_seen_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_level = rsp_scl_ff;
   assign rsp_chan.sda_drive = rsp_sda_ff;
   assign rsp_chan.busy_res  = rsp_busy_ff;
   assign rsp_chan.done_res  = rsp_done_ff;
   assign rsp_chan.rx_byte   = rsp_byte_ff;
   assign rsp_chan.rx_ack    = rsp_ack_ff;

   // a finished sequence never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff)
      else $error("done word reports busy");

   // idle engine keeps its phase position cleared
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (idx_ff == '0) && (tick_ff == '0))
      else $error("idle engine holds phase position");

   // phase position stays inside the running sequence
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < i2cm_pkg::seq_length(cmd_ff))
      else $error("phase index beyond sequence");

   // no response word appears without a word leaving the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response without request");

endmodule

`default_nettype wire
